// File: sv/btdw_pkg.sv
`default_nettype none
package btdw_pkg;

  localparam int MAX_WINDOW_DEF = 4096;
  localparam int MAX_ITEMS_DEF  = 65536;

  localparam int K_W    = 13;
  localparam int VAL_W  = 30;
  localparam int IDX_W  = 17;
  localparam int SUM_W  = 42;
  localparam int PAIR_W = 43;

  // depths of the internal queues, powers of two
  localparam int Q_DEPTH   = 4;
  localparam int OUT_DEPTH = 4;

  typedef struct packed {
    logic [VAL_W-1:0] sample_value;
    logic             is_last;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]  first_start;
    logic [IDX_W-1:0]  second_start;
    logic [PAIR_W-1:0] pair_sum;
    logic              result_valid;
  } out_item_t;

  // classified item handed from the front end to the back end
  typedef struct packed {
    logic             take;        // item is counted (no overflow)
    logic             sub;         // oldest value leaves the window
    logic             have_w;      // a full window ends here
    logic             cand;        // a left window exists for this one
    logic             first_cand;  // first pair candidate of the stream
    logic             first;       // first item of the stream
    logic             last;
    logic             res_valid;
    logic [IDX_W-1:0] start_idx;
    logic [IDX_W-1:0] left_idx;
    logic [VAL_W-1:0] sample_value;
    logic [VAL_W-1:0] old_value;
  } desc_t;

endpackage
`default_nettype wire

// File: sv/btdw_fifo.sv
`default_nettype none
module btdw_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       wr_en,
  input  wire logic [WIDTH-1:0]           wr_data,
  input  wire logic                       rd_en,
  output logic      [WIDTH-1:0]           rd_data,
  output logic                            empty,
  output logic      [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    count_r;

  assign rd_data = mem_r[rd_ptr_r];
  assign empty   = (count_r == '0);
  assign count   = count_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= PW'(wr_ptr_r + 1'b1);
      end
      if (rd_en) begin
        rd_ptr_r <= PW'(rd_ptr_r + 1'b1);
      end
      case ({wr_en, rd_en})
        2'b10:   count_r <= CW'(count_r + 1'b1);
        2'b01:   count_r <= CW'(count_r - 1'b1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: sv/btdw_front.sv
`default_nettype none
module btdw_front #(
  parameter int MAX_WINDOW = btdw_pkg::MAX_WINDOW_DEF,
  parameter int MAX_ITEMS  = btdw_pkg::MAX_ITEMS_DEF,
  localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1,
  localparam int QW = $bits(btdw_pkg::desc_t) + AW,
  localparam int QCW = $clog2(btdw_pkg::Q_DEPTH + 1)
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [btdw_pkg::K_W-1:0]      cfg_wr_data,
  input  wire logic                          in_push,
  output logic                               in_full,
  input  wire btdw_pkg::in_item_t            in_data,
  input  wire logic [QCW-1:0]                q_count,
  output logic                               q_wr_en,
  output logic [QW-1:0]                      q_wr_data
);

  localparam int KW    = btdw_pkg::K_W;
  localparam int CNT_W = $clog2(MAX_ITEMS + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ITEMS);

  logic [KW-1:0]    window_length_r;
  logic [CNT_W-1:0] count_r;
  logic [AW-1:0]    pos_r;
  logic             overflow_r;

  logic                            fr_valid_r;
  btdw_pkg::desc_t                 fr_desc_r;
  logic [AW-1:0]                   fr_wpos_r;
  logic [btdw_pkg::VAL_W-1:0]      vr_rd_r;
  logic [btdw_pkg::VAL_W-1:0]      value_ring [MAX_WINDOW];

  logic [KW-1:0]    keff;
  logic [31:0]      k32, i32, cnt_new32, s32;
  logic [CNT_W-1:0] i_cnt, cnt_new;
  logic [AW-1:0]    wpos;
  logic             accept, take, ovf_new;
  btdw_pkg::desc_t  desc_nxt, q_desc;

  // clamp the window length to 1..MAX_WINDOW
  always_comb begin
    if (window_length_r == '0) begin
      keff = KW'(1);
    end else if (32'(window_length_r) > 32'(MAX_WINDOW)) begin
      keff = KW'(MAX_WINDOW);
    end else begin
      keff = window_length_r;
    end
  end

  assign in_full = (32'(q_count) + 32'(fr_valid_r)) >= 32'(btdw_pkg::Q_DEPTH);
  assign accept  = in_push && !in_full;
  assign take    = (count_r < MAX_CNT);
  assign i_cnt   = CNT_W'(count_r + 1'b1);
  assign k32     = 32'(keff);
  assign i32     = 32'(i_cnt);
  assign s32     = i32 - k32 + 32'd1;
  assign wpos    = (32'(pos_r) == k32 - 32'd1) ? '0 : AW'(pos_r + 1'b1);
  assign ovf_new = overflow_r || !take;
  assign cnt_new = take ? i_cnt : count_r;
  assign cnt_new32 = 32'(cnt_new);

  always_comb begin
    desc_nxt              = '0;
    desc_nxt.take         = take;
    desc_nxt.sub          = i32 > k32;
    desc_nxt.have_w       = i32 >= k32;
    desc_nxt.cand         = i32 >= (k32 << 1);
    desc_nxt.first_cand   = i32 == (k32 << 1);
    desc_nxt.first        = (count_r == '0);
    desc_nxt.last         = in_data.is_last;
    desc_nxt.res_valid    = !ovf_new && (cnt_new32 >= (k32 << 1));
    desc_nxt.start_idx    = s32[btdw_pkg::IDX_W-1:0];
    desc_nxt.left_idx     = 17'(s32 - k32);
    desc_nxt.sample_value = in_data.sample_value;
  end

  // read the value leaving the window, then overwrite it
  always_ff @(posedge clk) begin
    if (accept && take) begin
      vr_rd_r         <= value_ring[pos_r];
      value_ring[pos_r] <= in_data.sample_value;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fr_desc_r <= desc_nxt;
      fr_wpos_r <= wpos;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_length_r <= KW'(1);
      count_r         <= '0;
      pos_r           <= '0;
      overflow_r      <= 1'b0;
      fr_valid_r      <= 1'b0;
    end else begin
      fr_valid_r <= accept;
      if (cfg_wr_en) begin
        window_length_r <= cfg_wr_data;
        count_r         <= '0;
        pos_r           <= '0;
        overflow_r      <= 1'b0;
      end else if (accept) begin
        if (in_data.is_last) begin
          count_r    <= '0;
          pos_r      <= '0;
          overflow_r <= 1'b0;
        end else if (take) begin
          count_r <= i_cnt;
          pos_r   <= wpos;
        end else begin
          overflow_r <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    q_desc           = fr_desc_r;
    q_desc.old_value = vr_rd_r;
  end

  assign q_wr_en   = fr_valid_r;
  assign q_wr_data = {fr_wpos_r, q_desc};

endmodule
`default_nettype wire

// File: sv/btdw_back.sv
`default_nettype none
module btdw_back #(
  parameter int MAX_WINDOW = btdw_pkg::MAX_WINDOW_DEF,
  localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1,
  localparam int QW = $bits(btdw_pkg::desc_t) + AW,
  localparam int OCW = $clog2(btdw_pkg::OUT_DEPTH + 1)
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic [QW-1:0]   q_rd_data,
  input  wire logic            q_empty,
  output logic                 q_rd_en,
  input  wire logic [OCW-1:0]  out_count,
  output logic                 res_wr_en,
  output btdw_pkg::out_item_t  res_wr_data
);

  localparam int SW = btdw_pkg::SUM_W;
  localparam int PW = btdw_pkg::PAIR_W;
  localparam int IW = btdw_pkg::IDX_W;
  localparam int DW = $bits(btdw_pkg::desc_t);

  btdw_pkg::desc_t d;
  logic [AW-1:0]   wpos;
  logic [SW-1:0]   w, base;
  logic [1:0]      lasts;

  logic [SW-1:0] rs_r;
  logic [SW-1:0] wsum_ring [MAX_WINDOW];
  logic [SW-1:0] left_rd_r;

  logic          b2_valid_r, b2_upd_r, b2_first_cand_r, b2_last_r, b2_res_valid_r;
  logic [IW-1:0] b2_start_r, b2_left_idx_r;
  logic [SW-1:0] b2_w_r;

  logic          b3_valid_r, b3_upd_r, b3_first_cand_r, b3_last_r, b3_res_valid_r;
  logic [IW-1:0] b3_start_r;
  logic [SW-1:0] b3_w_r;

  logic [SW-1:0] best_left_sum_r;
  logic [IW-1:0] best_left_idx_r;
  logic [PW-1:0] best_pair_r;
  logic [IW-1:0] best_first_r, best_second_r;

  logic          left_win, pair_win, take_pair;
  logic [PW-1:0] total, pair_new;
  logic [IW-1:0] first_new, second_new;

  assign d    = q_rd_data[DW-1:0];
  assign wpos = q_rd_data[QW-1:DW];

  // reserve an output slot for every result still in flight
  assign lasts   = {1'b0, b2_valid_r && b2_last_r} + {1'b0, b3_valid_r && b3_last_r};
  assign q_rd_en = !q_empty &&
                   ((32'(out_count) + 32'(lasts)) < 32'(btdw_pkg::OUT_DEPTH));

  // stage 1: slide the window sum
  assign base = d.first ? '0 : rs_r;
  assign w    = base - (d.sub ? SW'(d.old_value) : '0) + SW'(d.sample_value);

  always_ff @(posedge clk) begin
    if (q_rd_en && d.take && d.have_w) begin
      left_rd_r       <= wsum_ring[wpos];
      wsum_ring[wpos] <= w;
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd_en && d.take) begin
      rs_r <= w;
    end
    b2_upd_r        <= d.take && d.cand;
    b2_first_cand_r <= d.first_cand;
    b2_last_r       <= d.last;
    b2_res_valid_r  <= d.res_valid;
    b2_start_r      <= d.start_idx;
    b2_left_idx_r   <= d.left_idx;
    b2_w_r          <= w;
  end

  // stage 2: best earlier window
  assign left_win = b2_first_cand_r || (best_left_idx_r == '0) ||
                    (left_rd_r > best_left_sum_r);

  always_ff @(posedge clk) begin
    if (b2_valid_r && b2_upd_r && left_win) begin
      best_left_sum_r <= left_rd_r;
      best_left_idx_r <= b2_left_idx_r;
    end
    b3_upd_r        <= b2_upd_r;
    b3_first_cand_r <= b2_first_cand_r;
    b3_last_r       <= b2_last_r;
    b3_res_valid_r  <= b2_res_valid_r;
    b3_start_r      <= b2_start_r;
    b3_w_r          <= b2_w_r;
  end

  // stage 3: best pair, using the best left window as it stands after this item
  assign total      = PW'(best_left_sum_r) + PW'(b3_w_r);
  assign pair_win   = b3_first_cand_r || (best_first_r == '0) || (total > best_pair_r);
  assign take_pair  = b3_valid_r && b3_upd_r && pair_win;
  assign pair_new   = take_pair ? total : best_pair_r;
  assign first_new  = take_pair ? best_left_idx_r : best_first_r;
  assign second_new = take_pair ? b3_start_r : best_second_r;

  always_ff @(posedge clk) begin
    if (take_pair) begin
      best_pair_r   <= total;
      best_first_r  <= best_left_idx_r;
      best_second_r <= b3_start_r;
    end
  end

  assign res_wr_en = b3_valid_r && b3_last_r;

  always_comb begin
    res_wr_data = '0;
    if (b3_res_valid_r) begin
      res_wr_data.first_start  = first_new;
      res_wr_data.second_start = second_new;
      res_wr_data.pair_sum     = pair_new;
      res_wr_data.result_valid = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b2_valid_r <= 1'b0;
      b3_valid_r <= 1'b0;
    end else begin
      b2_valid_r <= q_rd_en;
      b3_valid_r <= b2_valid_r;
    end
  end

endmodule
`default_nettype wire

// File: sv/best_two_disjoint_windows_unit.sv
`default_nettype none
// Finds, over a stream of non-negative samples, the two non-overlapping windows of
// window_length samples whose combined sum is largest; ties go to the smallest first
// start, then the smallest second start. The unit takes one sample per clock cycle
// without gaps; in_full rises only when the result queue fills because results are
// not popped, since the back end holds a slot there for every result in flight.
// A sample's result (on the sample marked last) reaches the result queue, when
// nothing stalls, through the front-end register for the value-ring read, the
// transaction queue and the back-end registers for the window-sum ring read and
// the best left window, with the best pair formed as the result is written into
// the result queue. result_valid is 0, with all other fields
// 0, when fewer than twice window_length samples arrived or the stream ran past
// MAX_ITEMS. Write cfg_wr_data only while the unit is idle; a write restarts the
// stream, and so does every last sample. Window length 0 acts as 1, lengths above
// MAX_WINDOW saturate. Both rings need no clearing pass after reset.
module best_two_disjoint_windows_unit #(
  parameter int MAX_WINDOW = btdw_pkg::MAX_WINDOW_DEF,
  parameter int MAX_ITEMS  = btdw_pkg::MAX_ITEMS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_wr_en,
  input  wire logic [btdw_pkg::K_W-1:0] cfg_wr_data,
  input  wire logic                     in_push,
  output logic                          in_full,
  input  wire btdw_pkg::in_item_t       in_data,
  output logic                          out_empty,
  input  wire logic                     out_pop,
  output btdw_pkg::out_item_t           out_data
);

  localparam int AW  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int QW  = $bits(btdw_pkg::desc_t) + AW;
  localparam int QCW = $clog2(btdw_pkg::Q_DEPTH + 1);
  localparam int OCW = $clog2(btdw_pkg::OUT_DEPTH + 1);
  localparam int OW  = $bits(btdw_pkg::out_item_t);

  logic            q_wr_en, q_rd_en, q_empty;
  logic [QW-1:0]   q_wr_data, q_rd_data;
  logic [QCW-1:0]  q_count;

  logic                 res_wr_en;
  btdw_pkg::out_item_t  res_wr_data;
  logic [OW-1:0]        out_bits;
  logic [OCW-1:0]       out_count;

  // front end: count, classify, read the sample leaving the window
  btdw_front #(
    .MAX_WINDOW (MAX_WINDOW),
    .MAX_ITEMS  (MAX_ITEMS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_push     (in_push),
    .in_full     (in_full),
    .in_data     (in_data),
    .q_count     (q_count),
    .q_wr_en     (q_wr_en),
    .q_wr_data   (q_wr_data)
  );

  // hold classified transactions between the two ends
  btdw_fifo #(
    .WIDTH (QW),
    .DEPTH (btdw_pkg::Q_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_wr_en),
    .wr_data (q_wr_data),
    .rd_en   (q_rd_en),
    .rd_data (q_rd_data),
    .empty   (q_empty),
    .count   (q_count)
  );

  // back end: window sums, best left window, best pair
  btdw_back #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_rd_data   (q_rd_data),
    .q_empty     (q_empty),
    .q_rd_en     (q_rd_en),
    .out_count   (out_count),
    .res_wr_en   (res_wr_en),
    .res_wr_data (res_wr_data)
  );

  // results wait here until popped
  btdw_fifo #(
    .WIDTH (OW),
    .DEPTH (btdw_pkg::OUT_DEPTH)
  ) u_results (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_wr_en),
    .wr_data (res_wr_data),
    .rd_en   (out_pop && !out_empty),
    .rd_data (out_bits),
    .empty   (out_empty),
    .count   (out_count)
  );

  assign out_data = out_bits;

endmodule
`default_nettype wire

// File: sim/btdw_pair_checker.sv
module btdw_pair_checker
  import btdw_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cfg_wr_en,
  input  wire logic [K_W-1:0] cfg_wr_data,
  input  wire logic           in_push,
  input  wire logic           in_full,
  input  wire in_item_t       in_data,
  input  wire logic           out_empty,
  input  wire logic           out_pop,
  input  wire out_item_t      out_data,
  output int                  mismatches,
  output int                  pending,
  output int                  results_seen,
  output int                  valid_seen
);

  // Shadow of the unit's stream state.
  logic [K_W-1:0]    win_len;
  logic [VAL_W-1:0]  sample_ring [MAX_WINDOW_DEF];
  logic [SUM_W-1:0]  wsum_ring   [MAX_WINDOW_DEF];
  logic [SUM_W-1:0]  run_sum;
  logic [SUM_W-1:0]  left_best;
  logic [IDX_W-1:0]  left_start;
  logic [PAIR_W-1:0] pair_best;
  logic [IDX_W-1:0]  pair_first;
  logic [IDX_W-1:0]  pair_second;
  int unsigned       seen;
  logic              past_limit;

  out_item_t expected_pairs [$];

  function automatic int unsigned window_span();
    if (win_len == 0) return 1;
    if (win_len > MAX_WINDOW_DEF) return MAX_WINDOW_DEF;
    return win_len;
  endfunction

  task automatic clear_stream();
    run_sum     = '0;
    seen        = 0;
    left_best   = '0;
    left_start  = '0;
    pair_best   = '0;
    pair_first  = '0;
    pair_second = '0;
    past_limit  = 1'b0;
  endtask

  // Fold one sample into the scan; queue a result on the last sample.
  task automatic absorb_sample(input in_item_t item);
    int unsigned       k;
    int unsigned       idx;
    int unsigned       pos;
    int unsigned       wpos;
    int unsigned       strt;
    logic [SUM_W-1:0]  left;
    logic [PAIR_W-1:0] total;
    out_item_t         res;
    k = window_span();
    if (seen >= MAX_ITEMS_DEF) begin
      past_limit = 1'b1;
    end else begin
      idx  = seen + 1;
      pos  = (idx - 1) % k;
      wpos = idx % k;
      if (idx > k) run_sum = run_sum - sample_ring[pos];
      run_sum = run_sum + item.sample_value;
      sample_ring[pos] = item.sample_value;
      if (idx >= k) begin
        strt = idx - k + 1;
        if (idx >= 2 * k) begin
          left = wsum_ring[wpos];
          if (left_start == 0 || left > left_best) begin
            left_best  = left;
            left_start = IDX_W'(strt - k);
          end
          total = PAIR_W'(left_best) + PAIR_W'(run_sum);
          if (pair_first == 0 || total > pair_best) begin
            pair_best   = total;
            pair_first  = left_start;
            pair_second = IDX_W'(strt);
          end
        end
        wsum_ring[wpos] = run_sum;
      end
      seen = idx;
    end
    if (item.is_last) begin
      res = '0;
      if (!past_limit && seen >= 2 * k) begin
        res.first_start  = pair_first;
        res.second_start = pair_second;
        res.pair_sum     = pair_best;
        res.result_valid = 1'b1;
      end
      expected_pairs.push_back(res);
      clear_stream();
    end
  endtask

  task automatic note_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("%0t: mismatch on %s: got %0d, want %0d", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      win_len = K_W'(1);
      clear_stream();
      expected_pairs.delete();
      mismatches   = 0;
      results_seen = 0;
      valid_seen   = 0;
    end else begin
      if (cfg_wr_en) begin
        win_len = cfg_wr_data;
        clear_stream();
      end
      if (in_push && !in_full) absorb_sample(in_data);
      if (out_pop && !out_empty) begin
        results_seen++;
        if (expected_pairs.size() == 0) begin
          note_mismatch("unexpected result", out_data.pair_sum, 0);
        end else begin
          want = expected_pairs.pop_front();
          if (want.result_valid) valid_seen++;
          if (out_data.first_start !== want.first_start)
            note_mismatch("first_start", out_data.first_start, want.first_start);
          if (out_data.second_start !== want.second_start)
            note_mismatch("second_start", out_data.second_start, want.second_start);
          if (out_data.pair_sum !== want.pair_sum)
            note_mismatch("pair_sum", out_data.pair_sum, want.pair_sum);
          if (out_data.result_valid !== want.result_valid)
            note_mismatch("result_valid", out_data.result_valid, want.result_valid);
        end
      end
    end
    pending = expected_pairs.size();
  end

endmodule

// File: sim/tb_top.sv
module tb_top;
  import btdw_pkg::*;

  // Cycles with no transaction on either channel before the run is abandoned.
  // The longest legal quiet stretch is the deliberate result stall below.
  localparam int STALL_LIMIT = 3000;
  // Result hold-off used to fill the unit and back-pressure the input.
  localparam int HOLD_CYCLES = 400;
  // Extra cycles after the last expected result: covers the pipeline
  // plus the internal queues, for samples that yield no result.
  localparam int LATENCY_PAD = 16;

  localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};

  // How the sample values of one sequence are drawn.
  typedef enum int {
    VAL_FULL,  // any 30-bit value
    VAL_TINY,  // 0..3, to force ties between windows
    VAL_TOP,   // all ones
    VAL_EDGE,  // zero or all ones
    VAL_MID    // moderate values
  } value_mode_e;

  logic           clk = 1'b0;
  logic           rst_n;
  logic           cfg_wr_en;
  logic [K_W-1:0] cfg_wr_data;
  logic           in_push;
  logic           in_full;
  in_item_t       in_data;
  logic           out_empty;
  logic           out_pop;
  out_item_t      out_data;

  int mismatches;
  int pending;
  int results_seen;
  int valid_seen;

  int  samples_sent  = 0;
  int  streams_sent  = 0;
  int  tx_idle_pct   = 0;   // chance per sample of a sender gap
  int  rx_idle_pct   = 0;   // chance per cycle of a receiver gap
  bit  rx_hold_req   = 1'b0;
  int  quiet_cycles  = 0;

  always #5 clk = ~clk;

  best_two_disjoint_windows_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_data    (in_data),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_data   (out_data)
  );

  btdw_pair_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_push     (in_push),
    .in_full     (in_full),
    .in_data     (in_data),
    .out_empty   (out_empty),
    .out_pop     (out_pop),
    .out_data    (out_data),
    .mismatches  (mismatches),
    .pending     (pending),
    .results_seen(results_seen),
    .valid_seen  (valid_seen)
  );

  // Watchdog: abort when neither channel moves a transaction for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
      $display("tb_top failed");
      $finish;
    end
  end

  // Result side: pop freely, with random gaps, and one long hold-off on request.
  // Each pass drives out_pop once and then waits on the clock before the next pass.
  initial begin
    out_pop <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
        out_pop <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        out_pop <= 1'b1;
        @(posedge clk);
      end
    end
  end

  function automatic logic [VAL_W-1:0] pick_value(input value_mode_e mode);
    case (mode)
      VAL_TINY: return VAL_W'($urandom_range(0, 3));
      VAL_TOP:  return VAL_MAX;
      VAL_EDGE: return $urandom_range(0, 1) ? VAL_MAX : '0;
      VAL_MID:  return VAL_W'($urandom_range(0, 1000));
      default:  return VAL_W'($urandom());
    endcase
  endfunction

  // Offer one sample and hold it until the unit takes it. A sender gap,
  // when drawn, comes before the sample. in_push is left high on return,
  // so the caller either offers again or lowers it in the same step.
  task automatic offer(input logic [VAL_W-1:0] v, input logic last);
    if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= '{sample_value: v, is_last: last};
    @(posedge clk);
    while (in_full) @(posedge clk);
    samples_sent++;
    if (last) streams_sent++;
  endtask

  task automatic send_stream(input int len, input value_mode_e mode, input logic close);
    for (int i = 0; i < len; i++)
      offer(pick_value(mode), close && (i == len - 1));
  endtask

  // Drop the push, wait for every queued result (sampled away from the
  // active edge), then let the pipeline empty of result-less samples.
  task automatic settle();
    in_push <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (LATENCY_PAD) @(posedge clk);
  endtask

  // Write the window length while the unit is idle; this also restarts the stream.
  task automatic set_window(input logic [K_W-1:0] k);
    settle();
    cfg_wr_data <= k;
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Mostly complete sequences of at least two windows, some too short.
  task automatic random_phase(input logic [K_W-1:0] k, input int quota);
    int kk;
    int sent;
    int len;
    kk = (k == 0) ? 1 : int'(k);
    set_window(k);
    sent = 0;
    while (sent < quota) begin
      if ($urandom_range(0, 9) < 2) len = $urandom_range(1, 2 * kk - 1);
      else len = 2 * kk + $urandom_range(0, 3 * kk);
      send_stream(len, value_mode_e'($urandom_range(0, 4)), 1'b1);
      sent += len;
    end
  endtask

  initial begin
    rst_n       <= 1'b0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    in_push     <= 1'b0;
    in_data     <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, window length of one straight out of reset.
    offer('0, 1'b1);                 // lone sample: too short for a pair
    offer(VAL_MAX, 1'b0);            // two largest values: minimal valid pair
    offer(VAL_MAX, 1'b1);
    offer(30'd5, 1'b0);              // equal values: earliest starts must win
    offer(30'd5, 1'b0);
    offer(30'd5, 1'b1);

    set_window('0);                  // length zero behaves as one
    offer('0, 1'b0);
    offer(30'd9, 1'b0);
    offer(30'd9, 1'b1);

    set_window(13'd3);               // all-equal values: only one pair of windows fits in six samples
    for (int i = 0; i < 6; i++) offer(VAL_MAX, i == 5);

    // Leave a sequence open, then restart it with a register write.
    send_stream(4, VAL_FULL, 1'b0);
    set_window(13'd2);
    offer(30'd1, 1'b0);
    offer('0, 1'b0);
    offer('0, 1'b0);
    offer(30'd1, 1'b1);

    // Pressure: stall the result side while short sequences keep arriving,
    // so the result queue fills and in_full has to rise.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_window(13'd1);
    rx_hold_req = 1'b1;
    for (int i = 0; i < 40; i++) send_stream($urandom_range(1, 2), VAL_FULL, 1'b1);

    // Random part with idling on both sides; one stretch without any.
    tx_idle_pct = 15; rx_idle_pct = 10;
    random_phase(13'd2, 220);
    random_phase('0, 180);
    tx_idle_pct = 0; rx_idle_pct = 0;
    random_phase(13'd5, 220);
    tx_idle_pct = 25; rx_idle_pct = 20;
    random_phase(K_W'($urandom_range(1, 8)), 220);
    tx_idle_pct = 8; rx_idle_pct = 30;
    random_phase(K_W'($urandom_range(9, 32)), 260);
    tx_idle_pct = 30; rx_idle_pct = 5;
    random_phase(13'd3, 220);

    // Largest window and saturation above the maximum, on short sequences.
    tx_idle_pct = 1; rx_idle_pct = 1;
    set_window(13'd4096);
    send_stream(40, VAL_FULL, 1'b1);
    set_window(13'd8191);            // saturates; far too short for a pair
    send_stream(20, VAL_TINY, 1'b1);
    set_window(13'd4097);            // saturates
    send_stream(30, VAL_TOP, 1'b1);

    // Closing stretch at full rate on both sides.
    tx_idle_pct = 0; rx_idle_pct = 0;
    random_phase(K_W'($urandom_range(1, 16)), 250);

    settle();
    $display("covered %0d samples in %0d sequences; %0d results checked, %0d with a pair",
             samples_sent, streams_sent, results_seen, valid_seen);
    $display("window lengths 0 to 8191 with saturation, short sequences, and a long stall");
    if (mismatches == 0 && pending == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
